@@ src/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared types and constants of the neighbor force scatter-accumulate block
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int MAX_ATOMS_DEF = 1024;
  localparam int ACC_WIDTH_DEF = 48;

  localparam int AXES      = 3;
  localparam int INDEX_W   = 10;
  localparam int CONTRIB_W = 32;
  localparam int FORCE_W   = 48;
  localparam int CFG_W     = 11;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = AXES * FORCE_W;

  localparam logic [CFG_W-1:0] ATOMS_RESET = 11'd1024;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_t;

  // decode of the held item, handed to the merge stage
  typedef struct packed {
    logic read;
    logic in_range;
    logic skip;
  } ctrl_t;

endpackage

@@ src/nfsa_ram.sv @@
// ----------------------------------------------------------------------------
// nfsa_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/nfsa_lane.sv @@
// ----------------------------------------------------------------------------
// nfsa_lane
// one axis: saturating add of a contribution and clamp of the old value
// ----------------------------------------------------------------------------
module nfsa_lane #(
  parameter int ACC_WIDTH = nfsa_pkg::ACC_WIDTH_DEF
) (
  input  logic signed [ACC_WIDTH-1:0]          acc,
  input  logic signed [nfsa_pkg::CONTRIB_W-1:0] contrib,
  output logic signed [ACC_WIDTH-1:0]          sum,
  output logic                                 sat,
  output logic signed [nfsa_pkg::FORCE_W-1:0]  force_val
);

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH:0] raw;

  always_comb begin
    raw = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(contrib);
    sat = raw[ACC_WIDTH] != raw[ACC_WIDTH-1];
    if (sat) begin
      sum = raw[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sum = raw[ACC_WIDTH-1:0];
    end
  end

  // clamp into the force field range when the accumulator is wider
  if (ACC_WIDTH > nfsa_pkg::FORCE_W) begin : g_clamp
    logic [ACC_WIDTH-nfsa_pkg::FORCE_W:0] top;
    always_comb begin
      top = acc[ACC_WIDTH-1:nfsa_pkg::FORCE_W-1];
      if ((&top) || !(|top)) begin
        force_val = acc[nfsa_pkg::FORCE_W-1:0];
      end else if (acc[ACC_WIDTH-1]) begin
        force_val = {1'b1, {(nfsa_pkg::FORCE_W-1){1'b0}}};
      end else begin
        force_val = {1'b0, {(nfsa_pkg::FORCE_W-1){1'b1}}};
      end
    end
  end else begin : g_extend
    assign force_val = nfsa_pkg::FORCE_W'(acc);
  end

endmodule

@@ src/nfsa_merge.sv @@
// ----------------------------------------------------------------------------
// nfsa_merge
// combines the lane results into the write-back record and the result item
// ----------------------------------------------------------------------------
module nfsa_merge #(
  parameter int ACC_WIDTH = nfsa_pkg::ACC_WIDTH_DEF
) (
  input  nfsa_pkg::ctrl_t                                          ctrl,
  input  logic                                                     old_mark,
  input  logic [nfsa_pkg::AXES-1:0]                                lane_sat,
  input  logic [nfsa_pkg::AXES-1:0][ACC_WIDTH-1:0]                 lane_sum,
  input  logic [nfsa_pkg::AXES-1:0][nfsa_pkg::FORCE_W-1:0]         lane_force,
  output logic                                                     wr_en,
  output logic [nfsa_pkg::AXES*ACC_WIDTH:0]                        wr_data,
  output logic [nfsa_pkg::OUT_TDATA_W-1:0]                         res_data,
  output logic                                                     res_sat
);

  always_comb begin
    if (ctrl.read) begin
      wr_en    = ctrl.in_range;
      wr_data  = '0;
      res_data = ctrl.in_range ? lane_force : '0;
      res_sat  = ctrl.in_range & old_mark;
    end else begin
      wr_en    = !ctrl.skip;
      wr_data  = {old_mark | (|lane_sat), lane_sum};
      res_data = '0;
      res_sat  = 1'b0;
    end
  end

endmodule

@@ src/neighbor_force_scatter_accumulate.sv @@
// ----------------------------------------------------------------------------
// neighbor_force_scatter_accumulate
// per-atom 3-axis saturating force accumulator with read-and-clear
// ----------------------------------------------------------------------------
// After reset the block sweeps its force memory to zero, one atom a cycle, and
// takes no item until the sweep is done (config writes are taken throughout).
// For each item the accept edge launches the memory read, and the edge on which
// ST_MODIFY returns to idle writes the updated record back. The record memory
// has no forwarding path, so no new item is taken until that write-back is
// done, and this read-modify-write sets the rate. A read item also waits in
// ST_MODIFY while the previous result still sits in the output register.
// Accumulates into atom 0, into atoms at or above atoms_in_use or beyond the
// store are dropped; reads return the force and clear the record.
// ----------------------------------------------------------------------------
module neighbor_force_scatter_accumulate #(
  parameter int MAX_ATOMS = nfsa_pkg::MAX_ATOMS_DEF,
  parameter int ACC_WIDTH = nfsa_pkg::ACC_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // config: atoms_in_use
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nfsa_pkg::CFG_W-1:0]         cfg_data,
  // input item
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // atom_index[9:0], contrib_x[41:10], contrib_y[73:42], contrib_z[105:74], zero pad
  input  logic [nfsa_pkg::IN_TDATA_W-1:0]    s_tdata,
  // command[0]
  input  logic                               s_tuser,
  // result item
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // force_x[47:0], force_y[95:48], force_z[143:96]
  output logic [nfsa_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // saturated[0]
  output logic                               m_tuser
);

  localparam int AW    = $clog2(MAX_ATOMS);
  localparam int REC_W = nfsa_pkg::AXES * ACC_WIDTH + 1;
  localparam int CW    = nfsa_pkg::CONTRIB_W;
  localparam int IW    = nfsa_pkg::INDEX_W;

  nfsa_pkg::state_t state, state_next;

  logic [nfsa_pkg::CFG_W-1:0] atoms_in_use;

  // held item
  logic                           cmd;
  logic [IW-1:0]                  idx;
  logic [nfsa_pkg::AXES-1:0][CW-1:0] contrib;

  logic [AW-1:0] clr_addr;
  logic          accept;
  logic          advance;
  logic          out_free;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] ram_rdata;

  nfsa_pkg::ctrl_t ctrl;
  logic                                             mrg_we;
  logic [REC_W-1:0]                                 mrg_wdata;
  logic [nfsa_pkg::OUT_TDATA_W-1:0]                 res_data;
  logic                                             res_sat;
  logic [nfsa_pkg::AXES-1:0]                        lane_sat;
  logic [nfsa_pkg::AXES-1:0][ACC_WIDTH-1:0]         lane_sum;
  logic [nfsa_pkg::AXES-1:0][nfsa_pkg::FORCE_W-1:0] lane_force;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == nfsa_pkg::ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_in_use <= nfsa_pkg::ATOMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      atoms_in_use <= cfg_data;
    end
  end

  // item capture; the memory read is launched at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tuser;
      idx        <= s_tdata[IW-1:0];
      contrib[0] <= s_tdata[IW +: CW];
      contrib[1] <= s_tdata[IW+CW +: CW];
      contrib[2] <= s_tdata[IW+2*CW +: CW];
    end
  end

  // decode of the held item
  always_comb begin
    ctrl.read     = (cmd == nfsa_pkg::CMD_READ);
    ctrl.in_range = 32'(idx) < 32'(MAX_ATOMS);
    ctrl.skip     = (idx == '0) || (nfsa_pkg::CFG_W'(idx) >= atoms_in_use) || !ctrl.in_range;
  end

  // state machine: clearing sweep, idle, read-modify-write
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nfsa_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == nfsa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    unique case (state)
      nfsa_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(MAX_ATOMS - 1)) begin
          state_next = nfsa_pkg::ST_IDLE;
        end
      end
      nfsa_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = nfsa_pkg::ST_MODIFY;
        end
      end
      nfsa_pkg::ST_MODIFY: begin
        // a read holds here until the output register can take its result
        advance = !ctrl.read || out_free;
        if (advance) begin
          state_next = nfsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nfsa_pkg::ST_IDLE;
      end
    endcase
  end

  // write port: clearing sweep or write-back of the merged record
  always_comb begin
    if (state == nfsa_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = advance & mrg_we;
      ram_waddr = AW'(idx);
      ram_wdata = mrg_wdata;
    end
  end

  nfsa_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ATOMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(s_tdata[IW-1:0])),
    .rdata (ram_rdata)
  );

  // one lane per axis, record layout {mark, z, y, x}
  for (genvar a = 0; a < nfsa_pkg::AXES; a++) begin : g_lane
    nfsa_lane #(
      .ACC_WIDTH (ACC_WIDTH)
    ) u_lane (
      .acc       (ram_rdata[a*ACC_WIDTH +: ACC_WIDTH]),
      .contrib   (contrib[a]),
      .sum       (lane_sum[a]),
      .sat       (lane_sat[a]),
      .force_val (lane_force[a])
    );
  end

  nfsa_merge #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_merge (
    .ctrl       (ctrl),
    .old_mark   (ram_rdata[REC_W-1]),
    .lane_sat   (lane_sat),
    .lane_sum   (lane_sum),
    .lane_force (lane_force),
    .wr_en      (mrg_we),
    .wr_data    (mrg_wdata),
    .res_data   (res_data),
    .res_sat    (res_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && ctrl.read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.read) begin
      m_tdata <= res_data;
      m_tuser <= res_sat;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the neighbor force scatter-accumulate block: drives
// accumulate and read items with random gaps on both streams, tracks every
// atom's force record in a local model and compares each read result with it
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ATOM_COUNT    = nfsa_pkg::MAX_ATOMS_DEF;
  localparam int IDLE_MAX      = 14;
  // covers any item still inside the block
  localparam int SETTLE_CYCLES = 8;
  // the clearing sweep, the long hold and the random part fit many times over
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 200;

  localparam longint FORCE_MAX = (longint'(1) <<< (nfsa_pkg::FORCE_W - 1)) - 1;
  localparam longint FORCE_MIN = -FORCE_MAX - 1;

  localparam logic signed [nfsa_pkg::CONTRIB_W-1:0] CONTRIB_MAX = 32'sh7fff_ffff;
  localparam logic signed [nfsa_pkg::CONTRIB_W-1:0] CONTRIB_MIN = 32'sh8000_0000;

  localparam logic [nfsa_pkg::INDEX_W-1:0] TOP_ATOM = nfsa_pkg::INDEX_W'(ATOM_COUNT - 1);

  // one neighbor slot or read request as it crosses the input stream
  typedef struct packed {
    logic                                  cmd;
    logic [nfsa_pkg::INDEX_W-1:0]          atom;
    logic signed [nfsa_pkg::CONTRIB_W-1:0] cx;
    logic signed [nfsa_pkg::CONTRIB_W-1:0] cy;
    logic signed [nfsa_pkg::CONTRIB_W-1:0] cz;
  } slot_t;

  // one read result
  typedef struct packed {
    logic signed [nfsa_pkg::FORCE_W-1:0] fx;
    logic signed [nfsa_pkg::FORCE_W-1:0] fy;
    logic signed [nfsa_pkg::FORCE_W-1:0] fz;
    logic                                sat;
  } force_rec_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [nfsa_pkg::CFG_W-1:0]       cfg_data;
  logic                             s_tvalid;
  logic                             s_tready;
  // atom_index, contrib_x, contrib_y, contrib_z, zero pad
  logic [nfsa_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                             s_tuser;   // command
  logic                             m_tvalid;
  logic                             m_tready;
  logic [nfsa_pkg::OUT_TDATA_W-1:0] m_tdata;   // force_x, force_y, force_z
  logic                             m_tuser;   // saturated

  // local copy of the per-atom records and of atoms_in_use
  logic signed [nfsa_pkg::FORCE_W-1:0] model_force [ATOM_COUNT][nfsa_pkg::AXES];
  bit                                  model_sat [ATOM_COUNT];
  logic [nfsa_pkg::CFG_W-1:0]          model_atoms;

  // forces owed by reads already taken, oldest first
  force_rec_t pending_forces[$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int hold_request = 0;
  bit src_idle     = 1'b1;
  bit sink_idle    = 1'b1;

  neighbor_force_scatter_accumulate dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("neighbor_force_scatter_accumulate test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // force model
  // ---------------------------------------------------------------------------

  // saturating add of one q8.24 contribution into a q24.24 accumulator
  function automatic logic signed [nfsa_pkg::FORCE_W-1:0] clamp_add(
    input logic signed [nfsa_pkg::FORCE_W-1:0]   acc,
    input logic signed [nfsa_pkg::CONTRIB_W-1:0] c,
    inout bit                                    clamped
  );
    longint sum;
    sum = longint'(acc) + longint'(c);
    if (sum > FORCE_MAX) begin
      clamped = 1'b1;
      return nfsa_pkg::FORCE_W'(FORCE_MAX);
    end
    if (sum < FORCE_MIN) begin
      clamped = 1'b1;
      return nfsa_pkg::FORCE_W'(FORCE_MIN);
    end
    return nfsa_pkg::FORCE_W'(sum);
  endfunction

  // apply one accepted item to the model, queueing the force a read returns
  function automatic void apply_slot(input slot_t item);
    logic signed [nfsa_pkg::CONTRIB_W-1:0] c [nfsa_pkg::AXES];
    force_rec_t rec;
    bit clamped;
    c[0] = item.cx;
    c[1] = item.cy;
    c[2] = item.cz;
    clamped = 1'b0;
    if (item.cmd == nfsa_pkg::CMD_ACCUM) begin
      // empty slot and atoms outside the frame leave the store alone
      if (item.atom == 0 || item.atom >= model_atoms)
        return;
      for (int a = 0; a < nfsa_pkg::AXES; a++)
        model_force[item.atom][a] = clamp_add(model_force[item.atom][a], c[a], clamped);
      if (clamped)
        model_sat[item.atom] = 1'b1;
    end else begin
      // reads ignore the frame size and clear whatever they return
      rec.fx  = model_force[item.atom][0];
      rec.fy  = model_force[item.atom][1];
      rec.fz  = model_force[item.atom][2];
      rec.sat = model_sat[item.atom];
      for (int a = 0; a < nfsa_pkg::AXES; a++)
        model_force[item.atom][a] = '0;
      model_sat[item.atom] = 1'b0;
      pending_forces.push_back(rec);
    end
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < ATOM_COUNT; i++) begin
      for (int a = 0; a < nfsa_pkg::AXES; a++)
        model_force[i][a] = '0;
      model_sat[i] = 1'b0;
    end
    model_atoms = nfsa_pkg::ATOMS_RESET;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(
    input string                        name,
    input logic [nfsa_pkg::FORCE_W-1:0] want,
    input logic [nfsa_pkg::FORCE_W-1:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : force_monitor
    force_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_forces.size() == 0) begin
        $error("force result with no read outstanding");
        fail_count++;
      end else begin
        want = pending_forces.pop_front();
        check_field("force_x", want.fx, m_tdata[nfsa_pkg::FORCE_W-1:0]);
        check_field("force_y", want.fy, m_tdata[2*nfsa_pkg::FORCE_W-1:nfsa_pkg::FORCE_W]);
        check_field("force_z", want.fz,
                    m_tdata[3*nfsa_pkg::FORCE_W-1:2*nfsa_pkg::FORCE_W]);
        check_field("saturated", nfsa_pkg::FORCE_W'(want.sat),
                    nfsa_pkg::FORCE_W'(m_tuser));
      end
    end
  end

  // result side: random hold-offs per item, plus a long hold on request
  initial begin : force_sink
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(m_tvalid && m_tready) && hold_request == 0);
      @(negedge clk);
      // long stall so results pile up and the input side backs off
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic slot_t make_slot(
    input logic                                  cmd,
    input logic [nfsa_pkg::INDEX_W-1:0]          atom,
    input logic signed [nfsa_pkg::CONTRIB_W-1:0] x,
    input logic signed [nfsa_pkg::CONTRIB_W-1:0] y,
    input logic signed [nfsa_pkg::CONTRIB_W-1:0] z
  );
    slot_t s;
    s.cmd  = cmd;
    s.atom = atom;
    s.cx   = x;
    s.cy   = y;
    s.cz   = z;
    return s;
  endfunction

  // offer one item, hold it until taken, then update the model
  task automatic issue_slot(input slot_t item);
    int gap;
    gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= item.cmd;
    s_tdata  <= nfsa_pkg::IN_TDATA_W'({item.cz, item.cy, item.cx, item.atom});
    do begin
      @(posedge clk);
    end while (!(s_tvalid && s_tready));
    apply_slot(item);
    @(negedge clk);
  endtask

  // drop valid, let every owed result arrive, then let the pipe empty out
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_forces.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic set_atoms_in_use(input logic [nfsa_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    model_atoms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [nfsa_pkg::CONTRIB_W-1:0] pick_contrib();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return $urandom;
    if (r < 8)
      return $urandom_range(0, 2097152) - 1048576;
    case ($urandom_range(0, 4))
      0:       return CONTRIB_MAX;
      1:       return CONTRIB_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cleared store, empty slot, top atom, field extremes, read-and-clear
  task automatic test_directed();
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd0, '0, '0, '0));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, TOP_ATOM, '0, '0, '0));
    // empty slot is skipped, and atom 0 still reads as zero
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd0, CONTRIB_MAX, CONTRIB_MIN, -32'sd1));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd0, '0, '0, '0));
    // max then min on the highest atom nets -1 on every axis
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, TOP_ATOM, CONTRIB_MAX, CONTRIB_MAX,
                         CONTRIB_MAX));
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, TOP_ATOM, CONTRIB_MIN, CONTRIB_MIN,
                         CONTRIB_MIN));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, TOP_ATOM, '0, '0, '0));
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd1, CONTRIB_MIN, 32'sd0, CONTRIB_MAX));
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd1, 32'sd1, -32'sd1, 32'sd0));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd1, '0, '0, '0));
    // second read sees the cleared record
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd1, '0, '0, '0));
    wait_quiet();
  endtask

  // frame edge, zero atoms in use, a single atom, all register bits set
  task automatic test_frame_limits();
    set_atoms_in_use(11'd16);
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd16, 32'sd1, 32'sd2, 32'sd3));
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd15, 32'sd4, 32'sd5, 32'sd6));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd16, '0, '0, '0));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd15, '0, '0, '0));
    wait_quiet();
    set_atoms_in_use(11'd0);
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd3, 32'sd7, 32'sd8, 32'sd9));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd3, '0, '0, '0));
    wait_quiet();
    set_atoms_in_use(11'd1);
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, 10'd1, 32'sd7, 32'sd8, 32'sd9));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, 10'd1, '0, '0, '0));
    wait_quiet();
    set_atoms_in_use(11'd2047);
    issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, TOP_ATOM, -32'sd5, CONTRIB_MAX, 32'sd12));
    issue_slot(make_slot(nfsa_pkg::CMD_READ, TOP_ATOM, '0, '0, '0));
    wait_quiet();
    set_atoms_in_use(11'd1024);
  endtask

  // phases of mixed traffic, each with its own frame size and idle pattern
  task automatic test_random_traffic();
    logic [nfsa_pkg::CFG_W-1:0]   frame_sizes [8];
    logic [nfsa_pkg::INDEX_W-1:0] pool [8];
    logic [nfsa_pkg::INDEX_W-1:0] atom;
    logic                         cmd;
    int                           span;
    frame_sizes = '{11'd1, 11'd2047, 11'd0, 11'd1024, 11'd16, 11'd2, 11'd500, 11'd1024};
    frame_sizes[6] = nfsa_pkg::CFG_W'($urandom_range(3, ATOM_COUNT - 1));
    for (int p = 0; p < 8; p++) begin
      set_atoms_in_use(frame_sizes[p]);
      src_idle  = (p % 3 != 1);
      sink_idle = (p % 4 != 2);
      // a few hot atoms per phase so sums build up before they are read
      span = (model_atoms > ATOM_COUNT - 2) ? ATOM_COUNT - 1 : model_atoms + 1;
      for (int k = 0; k < 8; k++)
        pool[k] = nfsa_pkg::INDEX_W'($urandom_range(0, span));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        atom = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, 7)]
                                            : nfsa_pkg::INDEX_W'($urandom);
        cmd  = ($urandom_range(0, 99) < 25) ? nfsa_pkg::CMD_READ : nfsa_pkg::CMD_ACCUM;
        issue_slot(make_slot(cmd, atom, pick_contrib(), pick_contrib(), pick_contrib()));
      end
      wait_quiet();
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_atoms_in_use(11'd1024);
  endtask

  // result side holds off while reads stream in back to back
  task automatic test_backpressure();
    src_idle = 1'b0;
    for (int k = 1; k <= 8; k++)
      issue_slot(make_slot(nfsa_pkg::CMD_ACCUM, nfsa_pkg::INDEX_W'(k), pick_contrib(),
                           pick_contrib(), pick_contrib()));
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 40; n++)
      issue_slot(make_slot(nfsa_pkg::CMD_READ, nfsa_pkg::INDEX_W'($urandom_range(0, 9)),
                           '0, '0, '0));
    src_idle = 1'b1;
    wait_quiet();
  endtask

  initial begin : run_tests
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    clear_model();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // items wait out the clearing sweep through s_tready
    test_directed();
    test_frame_limits();
    test_random_traffic();
    test_backpressure();

    if (fail_count == 0)
      $display("neighbor_force_scatter_accumulate test passed");
    else
      $display("neighbor_force_scatter_accumulate test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/nfsa_pkg.sv
src/nfsa_ram.sv
src/nfsa_lane.sv
src/nfsa_merge.sv
src/neighbor_force_scatter_accumulate.sv
tb/tb_top.sv
